### hw/rtl/gbe_pkg.sv
package gbe_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 11;

  typedef enum logic [2:0] {
    CMD_INSERT      = 3'd0,
    CMD_BACKSPACE   = 3'd1,
    CMD_FORWARD     = 3'd2,
    CMD_BACKWARD    = 3'd3,
    CMD_READ_AFTER  = 3'd4,
    CMD_READ_BEFORE = 3'd5,
    CMD_CLEAR       = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_START = 2'd2,
    STAT_END   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [DATA_W-1:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] char_out;
    logic [1:0]        status;
    logic [LEN_W-1:0]  before_len;
    logic [LEN_W-1:0]  after_len;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Low LEN_W bits of a count, zero-extended when the count is narrower.
  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
    logic [LEN_W+CNT_W-1:0] ext;
    ext = (LEN_W + CNT_W)'(cnt);
    return ext[LEN_W-1:0];
  endfunction

endpackage

### hw/rtl/gbe_ram.sv
module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/gbe_ctrl.sv
module gbe_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gbe_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbe_pkg::out_item_t            out_data,
  output gbe_pkg::ram_req_t             ram_req,
  input  logic [gbe_pkg::DATA_W-1:0]    ram_rdata
);
  import gbe_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [2:0]        cmd_r;
  logic [DATA_W-1:0] char_r;
  logic [CNT_W-1:0]  pre_r, pre_nxt;
  logic [CNT_W-1:0]  post_r, post_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              slot_free;
  logic              commit;
  logic              full;
  logic [CNT_W-1:0]  pre_m1;
  logic [CNT_W-1:0]  after_idx;
  logic [CNT_W-1:0]  after_m1;
  logic [CNT_W:0]    used;

  logic [CNT_W-1:0]  ex_pre, ex_post;
  logic [DATA_W-1:0] ex_res;
  status_t           ex_stat;
  logic              ex_we;
  logic [CNT_W-1:0]  ex_waddr;
  logic [DATA_W-1:0] ex_wdata;

  assign used      = {1'b0, pre_r} + {1'b0, post_r};
  assign full      = (used == {1'b0, CAP_CNT});
  assign pre_m1    = pre_r - 1'b1;
  assign after_idx = CAP_CNT - post_r;
  assign after_m1  = after_idx - 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign commit    = (state_r == S_EXEC) && slot_free;

  // Execute the held command against the byte fetched when it was accepted.
  always_comb begin
    ex_pre   = pre_r;
    ex_post  = post_r;
    ex_res   = '0;
    ex_stat  = STAT_OK;
    ex_we    = 1'b0;
    ex_waddr = pre_r;
    ex_wdata = char_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          ex_stat = STAT_FULL;
        end else begin
          ex_we  = 1'b1;
          ex_pre = pre_r + 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        if (pre_r == '0) begin
          ex_stat = STAT_START;
        end else begin
          ex_pre = pre_m1;
          ex_res = ram_rdata;
        end
      end
      CMD_FORWARD: begin
        if (post_r == '0) begin
          ex_stat = STAT_END;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = ram_rdata;
          ex_pre   = pre_r + 1'b1;
          ex_post  = post_r - 1'b1;
        end
      end
      CMD_BACKWARD: begin
        if (pre_r == '0) begin
          ex_stat = STAT_START;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = after_m1;
          ex_wdata = ram_rdata;
          ex_pre   = pre_m1;
          ex_post  = post_r + 1'b1;
        end
      end
      CMD_READ_AFTER: begin
        if (post_r == '0) begin
          ex_stat = STAT_END;
        end else begin
          ex_res = ram_rdata;
        end
      end
      CMD_READ_BEFORE: begin
        if (pre_r == '0) begin
          ex_stat = STAT_START;
        end else begin
          ex_res = ram_rdata;
        end
      end
      CMD_CLEAR: begin
        ex_pre  = '0;
        ex_post = '0;
      end
      default: begin
      end
    endcase
  end

  // Next state, counts, result slot and memory port.
  always_comb begin
    state_nxt     = state_r;
    pre_nxt       = pre_r;
    post_nxt      = post_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ram_req.re    = accept;
    if (in_data.cmd inside {CMD_BACKSPACE, CMD_BACKWARD, CMD_READ_BEFORE}) begin
      ram_req.raddr = pre_m1[ADDR_W-1:0];
    end else begin
      ram_req.raddr = after_idx[ADDR_W-1:0];
    end
    ram_req.we    = commit && ex_we;
    ram_req.waddr = ex_waddr[ADDR_W-1:0];
    ram_req.wdata = ex_wdata;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt               = S_IDLE;
          pre_nxt                 = ex_pre;
          post_nxt                = ex_post;
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_out   = ex_res;
          out_data_nxt.status     = ex_stat;
          out_data_nxt.before_len = to_len(ex_pre);
          out_data_nxt.after_len  = to_len(ex_post);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pre_r       <= '0;
      post_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_r       <= pre_nxt;
      post_r      <= post_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.cmd;
      char_r <= in_data.char_in;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/gap_buffer_editor_top.sv
// Gap buffer editor: a byte store of CAPACITY entries with an edit cursor.
// Bytes before the cursor fill the store from the bottom, bytes after it
// fill from the top, and the gap lies between. Each command beat on the
// input channel (insert, backspace, forward, backward, read after, read
// before, clear) returns exactly one result beat carrying the byte read or
// removed, a status (ok, full, at start, at end) and both lengths after the
// command. The accept cycle issues one read of the byte memory, and the
// execute state then applies the command, writes the moved or inserted
// byte and loads the result register. One command is in flight at a time;
// a new command is taken while the previous result still waits in the
// output register, and a stalled output holds the execute state.
// The store has no reset; only the two counts clear, so no clearing pass.
module gap_buffer_editor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gbe_pkg::out_item_t out_data
);
  import gbe_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // Sequence commands, track the counts and hold the result beat.
  gbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Byte store: one write and one registered read per cycle.
  gbe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_text_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gbe_pkg::*;

  // Undefined command code: the block must leave everything alone.
  localparam logic [2:0] CMD_UNDEF = 3'd7;

  localparam int unsigned RANDOM_CMDS = 1800;
  localparam int unsigned FILL_AFTER  = 300;
  localparam int unsigned LONG_AT     = 400;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  gap_buffer_editor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One row of the directed table: the command beat, and where the answer
  // is obvious, the result typed in by hand.
  typedef struct {
    in_item_t  cmd_beat;
    bit        typed;
    out_item_t want;
  } edit_row_t;

  // Shadow copy of the editor: byte store plus the two lengths.
  logic [DATA_W-1:0] text_shadow [CAPACITY];
  int unsigned       pre_len;
  int unsigned       post_len;

  out_item_t   pending_results [$];
  edit_row_t   directed_rows [$];
  int unsigned cmds_issued;
  int unsigned results_seen;
  int unsigned fail_count;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at the start, then release it for good.
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one command to the shadow editor and return the result beat it
  // should produce.
  function automatic out_item_t apply_edit(input in_item_t it);
    out_item_t   r;
    int unsigned gap_len;
    int unsigned tail_idx;
    r        = '0;
    gap_len  = CAPACITY - pre_len - post_len;
    tail_idx = CAPACITY - post_len;
    case (it.cmd)
      CMD_INSERT: begin
        if (gap_len == 0) begin
          r.status = STAT_FULL;
        end else begin
          text_shadow[pre_len] = it.char_in;
          pre_len++;
        end
      end
      CMD_BACKSPACE: begin
        if (pre_len == 0) begin
          r.status = STAT_START;
        end else begin
          pre_len--;
          r.char_out = text_shadow[pre_len];
        end
      end
      CMD_FORWARD: begin
        // Move the first byte after the gap down to the cursor.
        if (post_len == 0) begin
          r.status = STAT_END;
        end else begin
          text_shadow[pre_len] = text_shadow[tail_idx];
          pre_len++;
          post_len--;
        end
      end
      CMD_BACKWARD: begin
        // Move the byte before the cursor up just under the tail.
        if (pre_len == 0) begin
          r.status = STAT_START;
        end else begin
          text_shadow[tail_idx - 1] = text_shadow[pre_len - 1];
          pre_len--;
          post_len++;
        end
      end
      CMD_READ_AFTER: begin
        if (post_len == 0) r.status = STAT_END;
        else r.char_out = text_shadow[tail_idx];
      end
      CMD_READ_BEFORE: begin
        if (pre_len == 0) r.status = STAT_START;
        else r.char_out = text_shadow[pre_len - 1];
      end
      CMD_CLEAR: begin
        pre_len  = 0;
        post_len = 0;
      end
      default: ;
    endcase
    r.before_len = LEN_W'(pre_len);
    r.after_len  = LEN_W'(post_len);
    return r;
  endfunction

  function automatic void plan_row(input logic [2:0] c, input logic [7:0] ch, input bit typed,
                                   input logic [7:0] ch_out, input status_t st,
                                   input int unsigned b_len, input int unsigned a_len);
    edit_row_t row;
    row.cmd_beat.cmd     = c;
    row.cmd_beat.char_in = ch;
    row.typed            = typed;
    row.want.char_out    = ch_out;
    row.want.status      = st;
    row.want.before_len  = LEN_W'(b_len);
    row.want.after_len   = LEN_W'(a_len);
    directed_rows.push_back(row);
  endfunction

  // Idle cycles per beat. Cycle through four moods every 64 beats so that
  // there are long runs without any idling as well as heavy idling.
  function automatic int unsigned draw_idle(input int unsigned n);
    case ((n / 64) % 4)
      0: return 0;
      1: return $urandom_range(0, 18);
      2: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Pick a command under one of four mixes: editing, cursor travel,
  // shrinking, and plain noise over all eight codes.
  function automatic logic [2:0] pick_cmd(input int unsigned mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      0: begin
        if (r < 40) return CMD_INSERT;
        if (r < 55) return CMD_BACKSPACE;
        if (r < 67) return CMD_FORWARD;
        if (r < 80) return CMD_BACKWARD;
        if (r < 88) return CMD_READ_AFTER;
        if (r < 96) return CMD_READ_BEFORE;
        if (r < 97) return CMD_CLEAR;
        return CMD_UNDEF;
      end
      1: begin
        if (r < 15) return CMD_INSERT;
        if (r < 20) return CMD_BACKSPACE;
        if (r < 50) return CMD_FORWARD;
        if (r < 80) return CMD_BACKWARD;
        if (r < 88) return CMD_READ_AFTER;
        if (r < 97) return CMD_READ_BEFORE;
        return CMD_UNDEF;
      end
      2: begin
        if (r < 10) return CMD_INSERT;
        if (r < 60) return CMD_BACKSPACE;
        if (r < 70) return CMD_FORWARD;
        if (r < 80) return CMD_BACKWARD;
        if (r < 88) return CMD_READ_AFTER;
        if (r < 96) return CMD_READ_BEFORE;
        if (r < 98) return CMD_CLEAR;
        return CMD_UNDEF;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // Offer one command beat, hold it until accepted, then log the result it
  // should produce. Drop valid only when a gap follows, so a back-to-back
  // beat never sees valid lowered and raised in the same step.
  task automatic issue_cmd(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = draw_idle(cmds_issued);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = apply_edit(it);
    pending_results.push_back(typed ? want : predicted);
    cmds_issued++;
  endtask

  task automatic send_cmd(input logic [2:0] c);
    in_item_t it;
    it.cmd     = c;
    it.char_in = 8'($urandom_range(0, 255));
    issue_cmd(it, 1'b0, '0);
  endtask

  // Fill the store to capacity, mostly by inserts with a few backward
  // moves so the tail is not empty. Then poke at the full store: refused
  // inserts, travel to the end (before_len reaches CAPACITY), and clear.
  task automatic fill_to_capacity();
    while (pre_len + post_len < CAPACITY) begin
      if ($urandom_range(0, 99) < 4) send_cmd(CMD_BACKWARD);
      else if ($urandom_range(0, 99) < 2) send_cmd(CMD_READ_BEFORE);
      else send_cmd(CMD_INSERT);
    end
    repeat (3) send_cmd(CMD_INSERT);
    send_cmd(CMD_BACKWARD);
    send_cmd(CMD_INSERT);
    while (post_len > 0) send_cmd(CMD_FORWARD);
    send_cmd(CMD_FORWARD);
    send_cmd(CMD_READ_AFTER);
    send_cmd(CMD_READ_BEFORE);
    send_cmd(CMD_BACKSPACE);
    send_cmd(CMD_INSERT);
    send_cmd(CMD_INSERT);
    send_cmd(CMD_BACKWARD);
    send_cmd(CMD_READ_AFTER);
    send_cmd(CMD_CLEAR);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Command side: directed table first, then random segments with one
  // fill-to-capacity pass in the middle.
  initial begin : cmd_side
    in_item_t    it;
    int unsigned mix;
    int unsigned seg;
    bit          filled;
    pre_len      = 0;
    post_len     = 0;
    cmds_issued  = 0;
    results_seen = 0;
    fail_count   = 0;
    filled       = 1'b0;

    // Refusals on an empty store, then a short edit that walks the cursor
    // across three bytes holding the byte extremes.
    plan_row(CMD_READ_BEFORE, 8'h11, 1, 8'h00, STAT_START, 0, 0);
    plan_row(CMD_READ_AFTER,  8'h22, 1, 8'h00, STAT_END,   0, 0);
    plan_row(CMD_BACKSPACE,   8'h33, 1, 8'h00, STAT_START, 0, 0);
    plan_row(CMD_BACKWARD,    8'h44, 1, 8'h00, STAT_START, 0, 0);
    plan_row(CMD_FORWARD,     8'h55, 1, 8'h00, STAT_END,   0, 0);
    plan_row(CMD_UNDEF,       8'hFF, 1, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_INSERT,      8'h00, 1, 8'h00, STAT_OK,    1, 0);
    plan_row(CMD_INSERT,      8'hFF, 1, 8'h00, STAT_OK,    2, 0);
    plan_row(CMD_INSERT,      8'hA5, 1, 8'h00, STAT_OK,    3, 0);
    plan_row(CMD_READ_BEFORE, 8'h00, 1, 8'hA5, STAT_OK,    3, 0);
    plan_row(CMD_BACKWARD,    8'h5A, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_READ_AFTER,  8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_READ_BEFORE, 8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_BACKWARD,    8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_BACKWARD,    8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_BACKWARD,    8'h00, 1, 8'h00, STAT_START, 0, 3);
    plan_row(CMD_READ_AFTER,  8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_FORWARD,     8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_BACKSPACE,   8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_FORWARD,     8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_FORWARD,     8'h00, 0, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_FORWARD,     8'h00, 1, 8'h00, STAT_END,   2, 0);
    plan_row(CMD_INSERT,      8'h5A, 1, 8'h00, STAT_OK,    3, 0);
    plan_row(CMD_CLEAR,       8'h00, 1, 8'h00, STAT_OK,    0, 0);
    plan_row(CMD_READ_BEFORE, 8'h00, 1, 8'h00, STAT_START, 0, 0);

    @(posedge clk iff rst_n);
    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd_beat, directed_rows[i].typed, directed_rows[i].want);

    while (cmds_issued < directed_rows.size() + RANDOM_CMDS) begin
      if (!filled && cmds_issued >= FILL_AFTER) begin
        fill_to_capacity();
        filled = 1'b1;
      end else begin
        mix = $urandom_range(0, 3);
        seg = $urandom_range(16, 96);
        repeat (seg) begin
          it.cmd     = pick_cmd(mix);
          it.char_in = 8'($urandom_range(0, 255));
          issue_cmd(it, 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every pending result, then keep idling with in_valid
    // low so that anything stray can still show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: stall for a drawn number of cycles per beat, with one long
  // hold-off so the block backs up and drops in_ready. Check every accepted
  // beat against the oldest pending result.
  initial begin : result_side
    out_item_t   want;
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && out_ready) begin
          if (pending_results.size() == 0) begin
            $error("result beat with no command pending");
            fail_count++;
          end else begin
            want = pending_results.pop_front();
            check_field("char_out",   16'(want.char_out),   16'(out_data.char_out));
            check_field("status",     16'(want.status),     16'(out_data.status));
            check_field("before_len", 16'(want.before_len), 16'(out_data.before_len));
            check_field("after_len",  16'(want.after_len),  16'(out_data.after_len));
          end
          results_seen++;
          hold = (results_seen == LONG_AT) ? LONG_HOLD : draw_idle(results_seen);
        end else if (hold > 0) begin
          hold--;
        end
        out_ready <= (hold == 0);
      end
    end
  end

  // Timeout: stop a hung run.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hw/rtl/gbe_pkg.sv
hw/rtl/gbe_ram.sv
hw/rtl/gbe_ctrl.sv
hw/rtl/gap_buffer_editor_top.sv
dv/tb.sv
